// ----- sv/gn3_pkg.sv -----
`timescale 1ns / 1ps

package gn3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PERM_DEPTH    = 256;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic {
    FN_LOAD = 1'b0,
    FN_EVAL = 1'b1
  } func_t;

endpackage

// ----- sv/gn3_front.sv -----
`timescale 1ns / 1ps

module gn3_front #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  gn3_pkg::func_t         in_func,
  input  logic [7:0]             in_entry_index,
  input  logic [7:0]             in_entry_value,
  input  logic [FRAC_BITS+7:0]   in_x_coord,
  input  logic [FRAC_BITS+7:0]   in_y_coord,
  input  logic [FRAC_BITS+7:0]   in_z_coord,
  output logic                   q_valid,
  input  logic                   q_pop,
  output gn3_pkg::func_t         q_func,
  output logic [7:0]             q_idx,
  output logic [7:0]             q_val,
  output logic [FRAC_BITS+7:0]   q_x,
  output logic [FRAC_BITS+7:0]   q_y,
  output logic [FRAC_BITS+7:0]   q_z
);
  import gn3_pkg::*;

  localparam int CW  = FRAC_BITS + 8;
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  func_t           func_q_r [QUEUE_DEPTH];
  logic [7:0]      idx_q_r  [QUEUE_DEPTH];
  logic [7:0]      val_q_r  [QUEUE_DEPTH];
  logic [CW-1:0]   x_q_r    [QUEUE_DEPTH];
  logic [CW-1:0]   y_q_r    [QUEUE_DEPTH];
  logic [CW-1:0]   z_q_r    [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  cnt_r, cnt_nxt;
  logic            push;

  assign busy    = (cnt_r == QCW'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_func  = func_q_r[rd_ptr_r];
  assign q_idx   = idx_q_r[rd_ptr_r];
  assign q_val   = val_q_r[rd_ptr_r];
  assign q_x     = x_q_r[rd_ptr_r];
  assign q_y     = y_q_r[rd_ptr_r];
  assign q_z     = z_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = QCW'(cnt_r + 1'b1);
    end else if (!push && q_pop) begin
      cnt_nxt = QCW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      func_q_r[wr_ptr_r] <= in_func;
      idx_q_r[wr_ptr_r]  <= in_entry_index;
      val_q_r[wr_ptr_r]  <= in_entry_value;
      x_q_r[wr_ptr_r]    <= in_x_coord;
      y_q_r[wr_ptr_r]    <= in_y_coord;
      z_q_r[wr_ptr_r]    <= in_z_coord;
    end
  end

endmodule

// ----- sv/gn3_back.sv -----
`timescale 1ns / 1ps

module gn3_back #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  gn3_pkg::func_t              q_func,
  input  logic [7:0]                  q_idx,
  input  logic [7:0]                  q_val,
  input  logic [FRAC_BITS+7:0]        q_x,
  input  logic [FRAC_BITS+7:0]        q_y,
  input  logic [FRAC_BITS+7:0]        q_z,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_noise_value
);
  import gn3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = F + 6;
  localparam int TW = F + 1;
  localparam int PW = VW + TW + 1;
  localparam int OW = F + 2;

  localparam logic [4:0] OP_LERP = 5'd12;
  localparam logic [4:0] OP_YZ   = 5'd16;
  localparam logic [4:0] OP_ZL   = 5'd18;
  localparam logic [3:0] RS_DONE = 4'd15;

  localparam logic signed [VW-1:0] FX_ONE  = {{(VW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [VW-1:0] FX_TEN  = (FX_ONE <<< 3) + (FX_ONE <<< 1);
  localparam logic signed [VW-1:0] LIM_HI  = (FX_ONE <<< 1) - 1;
  localparam logic signed [VW-1:0] LIM_LO  = -(FX_ONE <<< 1);
  localparam logic signed [PW-1:0] FX_HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] m;
    logic signed [PW-1:0] s;
    logic signed [PW-1:0] s_neg;
    begin
      m     = p[PW-1] ? -p : p;
      s     = (m + FX_HALF) >>> F;
      s_neg = -s;
      rnd   = p[PW-1] ? s_neg[VW-1:0] : s[VW-1:0];
    end
  endfunction

  function automatic logic signed [VW-1:0] grad(
    input logic [3:0] h,
    input logic signed [VW-1:0] gx,
    input logic signed [VW-1:0] gy,
    input logic signed [VW-1:0] gz
  );
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] v;
    begin
      u = (h < 4'd8) ? gx : gy;
      v = (h < 4'd4) ? gy : ((h == 4'd12 || h == 4'd14) ? gx : gz);
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      grad = u + v;
    end
  endfunction

  state_t               state_r;
  logic                 out_valid_r;
  logic signed [OW-1:0] out_val_r;
  logic [4:0]           op_r;
  logic                 ph_r;
  logic [3:0]           rs_r;

  logic [7:0]           perm_mem [PERM_DEPTH];
  logic [7:0]           rdata_r;
  logic [7:0]           rd_addr;

  logic [7:0]           xi_r, yi_r, zi_r;
  logic [F-1:0]         xf_r, yf_r, zf_r;
  logic [7:0]           a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic [3:0]           hash_r [8];
  logic signed [VW-1:0] fb_r;
  logic [TW-1:0]        fu_r, fv_r, fw_r;
  logic signed [VW-1:0] lv_r [4];
  logic signed [PW-1:0] prod_r;

  logic [2:0]           corner;
  logic [7:0]           base;
  logic signed [VW-1:0] gx0, gx1, gy0, gy1, gz0, gz1, gy, gz, ga, gb;
  logic [F-1:0]         t_frac;
  logic signed [VW-1:0] t_ext;
  logic signed [VW-1:0] rnd_c;
  logic signed [VW-1:0] mul_a;
  logic [TW-1:0]        mul_t;
  logic signed [VW-1:0] lerp_a, lerp_b;
  logic [TW-1:0]        lerp_t;
  logic signed [VW-1:0] lerp_res;
  logic signed [VW-1:0] fade_b;
  logic signed [VW-1:0] fade_end;
  logic signed [OW-1:0] sat_res;
  logic                 is_fade;
  logic                 is_lerp_x;

  assign q_pop           = (state_r == ST_IDLE) && q_valid;
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_val_r;

  // hash read schedule: X, X+1, A, A+1, B, B+1, then the eight corners
  always_comb begin
    corner = 3'(rs_r - 4'd6);
    unique case (corner[1:0])
      2'd0:    base = aa_r;
      2'd1:    base = ba_r;
      2'd2:    base = ab_r;
      default: base = bb_r;
    endcase
    unique case (rs_r)
      4'd0:    rd_addr = xi_r;
      4'd1:    rd_addr = 8'(xi_r + 8'd1);
      4'd2:    rd_addr = a_r;
      4'd3:    rd_addr = 8'(a_r + 8'd1);
      4'd4:    rd_addr = b_r;
      4'd5:    rd_addr = 8'(b_r + 8'd1);
      default: rd_addr = 8'(base + {7'd0, corner[2]});
    endcase
  end

  always_comb begin
    gx0 = $signed({{(VW-F){1'b0}}, xf_r});
    gy0 = $signed({{(VW-F){1'b0}}, yf_r});
    gz0 = $signed({{(VW-F){1'b0}}, zf_r});
    gx1 = gx0 - FX_ONE;
    gy1 = gy0 - FX_ONE;
    gz1 = gz0 - FX_ONE;
    // corner pair (2j, 2j+1) always sits at the bottom of the hash shift line
    gy  = op_r[0] ? gy1 : gy0;
    gz  = op_r[1] ? gz1 : gz0;
    ga  = grad(hash_r[0], gx0, gy, gz);
    gb  = grad(hash_r[1], gx1, gy, gz);

    unique case (op_r[3:2])
      2'd0:    t_frac = xf_r;
      2'd1:    t_frac = yf_r;
      default: t_frac = zf_r;
    endcase
    t_ext = $signed({{(VW-F){1'b0}}, t_frac});

    rnd_c     = rnd(prod_r);
    is_fade   = (op_r < OP_LERP);
    is_lerp_x = !is_fade && (op_r < OP_YZ);

    if (is_lerp_x) begin
      lerp_a = ga;
      lerp_b = gb;
      lerp_t = fu_r;
    end else begin
      lerp_a = lv_r[0];
      lerp_b = lv_r[1];
      lerp_t = (op_r == OP_ZL) ? fw_r : fv_r;
    end
    lerp_res = lerp_a + rnd_c;

    if (is_fade) begin
      mul_a = (op_r[1:0] == 2'd0) ? t_ext : fb_r;
      mul_t = {1'b0, t_frac};
    end else begin
      mul_a = lerp_b - lerp_a;
      mul_t = lerp_t;
    end

    fade_b = (rnd_c <<< 2) + (rnd_c <<< 1) - ((t_ext <<< 4) - t_ext) + FX_TEN;
    if (fade_b < 0) fade_b = '0;
    fade_end = (rnd_c > FX_ONE) ? FX_ONE : rnd_c;

    if (lerp_res > LIM_HI) begin
      sat_res = OUT_MAX;
    end else if (lerp_res < LIM_LO) begin
      sat_res = OUT_MIN;
    end else begin
      sat_res = lerp_res[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= '0;
      ph_r        <= 1'b0;
      rs_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid && q_func == FN_EVAL) begin
            state_r <= ST_EVAL;
            op_r    <= '0;
            ph_r    <= 1'b0;
            rs_r    <= '0;
          end
        end
        ST_EVAL: begin
          if (rs_r != RS_DONE) rs_r <= 4'(rs_r + 4'd1);
          ph_r <= !ph_r;
          if (ph_r) begin
            op_r <= 5'(op_r + 5'd1);
            if (op_r == OP_ZL) begin
              out_valid_r <= 1'b1;
              out_val_r   <= sat_res;
              state_r     <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= perm_mem[rd_addr];
    if (q_pop && q_func == FN_LOAD) begin
      perm_mem[q_idx] <= q_val;
    end
  end

  // fades finish well after the last hash read
  always_ff @(posedge clk) begin
    if (q_pop && q_func == FN_EVAL) begin
      xi_r <= q_x[F+7:F];
      yi_r <= q_y[F+7:F];
      zi_r <= q_z[F+7:F];
      xf_r <= q_x[F-1:0];
      yf_r <= q_y[F-1:0];
      zf_r <= q_z[F-1:0];
    end
    if (state_r == ST_EVAL) begin
      unique case (rs_r)
        4'd1: a_r  <= 8'(rdata_r + yi_r);
        4'd2: b_r  <= 8'(rdata_r + yi_r);
        4'd3: aa_r <= 8'(rdata_r + zi_r);
        4'd4: ab_r <= 8'(rdata_r + zi_r);
        4'd5: ba_r <= 8'(rdata_r + zi_r);
        4'd6: bb_r <= 8'(rdata_r + zi_r);
        4'd0, RS_DONE: ;
        default: begin
          for (int i = 0; i < 7; i++) hash_r[i] <= hash_r[i+1];
          hash_r[7] <= rdata_r[3:0];
        end
      endcase

      if (!ph_r) begin
        prod_r <= mul_a * $signed({1'b0, mul_t});
      end else if (is_fade) begin
        unique case (op_r[1:0])
          2'd0: fb_r <= fade_b;
          2'd3: begin
            unique case (op_r[3:2])
              2'd0:    fu_r <= fade_end[TW-1:0];
              2'd1:    fv_r <= fade_end[TW-1:0];
              default: fw_r <= fade_end[TW-1:0];
            endcase
          end
          default: fb_r <= rnd_c;
        endcase
      end else if (is_lerp_x) begin
        lv_r[op_r[1:0]] <= lerp_res;
        for (int i = 0; i < 6; i++) hash_r[i] <= hash_r[i+2];
      end else if (op_r != OP_ZL) begin
        lv_r[0] <= lv_r[2];
        if (op_r == OP_YZ) begin
          lv_r[1] <= lv_r[3];
          lv_r[2] <= lerp_res;
        end else begin
          lv_r[1] <= lerp_res;
        end
      end
    end
  end

endmodule

// ----- sv/gradient_noise_3d.sv -----
`timescale 1ns / 1ps

// Improved 3D gradient noise.
// Input: pulse start with the item on the in_ ports; the item is taken at the
// edge where start is high and busy is low. in_func selects a load (writes
// in_entry_value into permutation entry in_entry_index) or an evaluate (point
// in_x/y/z_coord, unsigned Q8.FRAC_BITS, wrapped modulo 256).
// Output: each evaluate yields one out_noise_value (signed Q2.FRAC_BITS),
// shown for exactly one cycle with out_valid high. Loads yield nothing.
// A two-entry queue sits behind the input, so busy only rises when it fills.
// An evaluate runs in the back end after it leaves the queue; a load is
// written to the table as it leaves the queue. The back end takes no new
// item until an evaluate is done. The single shared multiplier runs 19
// multiply/round steps in turn; the 14 dependent table reads overlap with
// the fade steps.
// The receiver cannot stall; results are never held.
// Reset clears the queue and sequencer; the permutation table is not cleared
// and every entry a point touches must be loaded first.
module gradient_noise_3d #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  gn3_pkg::func_t              in_func,
  input  logic [7:0]                  in_entry_index,
  input  logic [7:0]                  in_entry_value,
  input  logic [FRAC_BITS+7:0]        in_x_coord,
  input  logic [FRAC_BITS+7:0]        in_y_coord,
  input  logic [FRAC_BITS+7:0]        in_z_coord,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_noise_value
);
  import gn3_pkg::*;

  logic                  q_valid;
  logic                  q_pop;
  func_t                 q_func;
  logic [7:0]            q_idx;
  logic [7:0]            q_val;
  logic [FRAC_BITS+7:0]  q_x, q_y, q_z;

  gn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_z_coord     (in_z_coord),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_func         (q_func),
    .q_idx          (q_idx),
    .q_val          (q_val),
    .q_x            (q_x),
    .q_y            (q_y),
    .q_z            (q_z)
  );

  gn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_func          (q_func),
    .q_idx           (q_idx),
    .q_val           (q_val),
    .q_x             (q_x),
    .q_y             (q_y),
    .q_z             (q_z),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

endmodule

// ----- sim/gradient_noise_3d_tb.sv -----
`timescale 1ns / 1ps

module gradient_noise_3d_tb;
  import gn3_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int CW = FB + 8;
  localparam int OW = FB + 2;
  localparam longint ONE = longint'(1) << FB;
  localparam longint HALF = longint'(1) << (FB - 1);
  localparam longint LIMIT_CYCLES = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  func_t in_func;
  logic [7:0] in_entry_index;
  logic [7:0] in_entry_value;
  logic [CW-1:0] in_x_coord;
  logic [CW-1:0] in_y_coord;
  logic [CW-1:0] in_z_coord;
  logic out_valid;
  logic signed [OW-1:0] out_noise_value;

  gradient_noise_3d dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value), .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord), .in_z_coord(in_z_coord),
    .out_valid(out_valid), .out_noise_value(out_noise_value)
  );

  typedef struct {
    func_t fn;
    logic [7:0] idx;
    logic [7:0] val;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    bit known;
    logic [OW-1:0] want;
  } stim_t;

  logic [7:0] perm [256];
  logic [OW-1:0] noise_q [$];
  int errors;
  longint cycles;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_q(longint v);
    if (v >= 0) return (v + HALF) >>> FB;
    return -((-v + HALF) >>> FB);
  endfunction

  function automatic longint fade(longint t);
    longint p, b;
    p = round_q(t * t);
    b = 6 * p - 15 * t + 10 * ONE;
    if (b < 0) b = 0;
    b = round_q(b * t);
    b = round_q(b * t);
    b = round_q(b * t);
    if (b > ONE) b = ONE;
    return b;
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + round_q(t * (b - a));
  endfunction

  function automatic longint grad(logic [7:0] hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [OW-1:0] noise_at(logic [CW-1:0] cx, logic [CW-1:0] cy,
                                             logic [CW-1:0] cz);
    logic [7:0] xi, yi, zi, a, aa, ab, b, ba, bb;
    longint x, y, z, x1, y1, z1, u, v, w, r, lim;
    xi = cx[CW-1:FB]; yi = cy[CW-1:FB]; zi = cz[CW-1:FB];
    x = cx[FB-1:0]; y = cy[FB-1:0]; z = cz[FB-1:0];
    x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
    u = fade(x); v = fade(y); w = fade(z);
    a = perm[xi] + yi;
    aa = perm[a] + zi;
    ab = perm[8'(a + 1)] + zi;
    b = perm[8'(xi + 1)] + yi;
    ba = perm[b] + zi;
    bb = perm[8'(b + 1)] + zi;
    r = blend(w,
      blend(v, blend(u, grad(perm[aa], x, y, z), grad(perm[ba], x1, y, z)),
               blend(u, grad(perm[ab], x, y1, z), grad(perm[bb], x1, y1, z))),
      blend(v, blend(u, grad(perm[8'(aa + 1)], x, y, z1),
                        grad(perm[8'(ba + 1)], x1, y, z1)),
               blend(u, grad(perm[8'(ab + 1)], x, y1, z1),
                        grad(perm[8'(bb + 1)], x1, y1, z1))));
    lim = longint'(1) << (FB + 1);
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r[OW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [OW-1:0] got, logic [OW-1:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Results are sampled at the edge, before the driver's updates land.
  always @(posedge clk) begin
    logic [OW-1:0] want;
    if (rst_n && out_valid) begin
      if (noise_q.size() == 0) begin
        report_mismatch("unexpected noise_value", out_noise_value, '0);
      end else begin
        want = noise_q.pop_front();
        if (out_noise_value !== want)
          report_mismatch("noise_value", out_noise_value, want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("FAILURE");
      $finish;
    end
  end

  // Holds start high until the item is taken; the model update happens at accept.
  // start stays high on return so back-to-back items need no gap; idle cycles
  // and pauses drop it.
  task automatic send(stim_t s);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= s.fn;
    in_entry_index <= s.idx;
    in_entry_value <= s.val;
    in_x_coord <= s.x;
    in_y_coord <= s.y;
    in_z_coord <= s.z;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (s.fn == FN_LOAD) begin
      perm[s.idx] = s.val;
    end else begin
      if (s.known && s.want !== noise_at(s.x, s.y, s.z))
        report_mismatch("table row vs predictor", noise_at(s.x, s.y, s.z), s.want);
      noise_q.push_back(s.known ? s.want : noise_at(s.x, s.y, s.z));
    end
  endtask

  function automatic stim_t load_item(logic [7:0] i, logic [7:0] v);
    stim_t s;
    s = '{FN_LOAD, i, v, '0, '0, '0, 1'b0, '0};
    s.x = CW'($urandom); s.y = CW'($urandom); s.z = CW'($urandom);
    return s;
  endfunction

  function automatic stim_t eval_item(logic [CW-1:0] x, logic [CW-1:0] y,
                                      logic [CW-1:0] z);
    stim_t s;
    s = '{FN_EVAL, 8'($urandom), 8'($urandom), x, y, z, 1'b0, '0};
    return s;
  endfunction

  initial begin
    stim_t dir [$];
    stim_t s;
    int n;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FN_LOAD;
    in_entry_index = '0;
    in_entry_value = '0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_z_coord = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table first with a scrambled permutation.
    for (int i = 0; i < 256; i++) send(load_item(i[7:0], 8'(i * 167 + 13)));

    // Directed rows, checked against the predictor unless a hand value is given.
    dir.push_back(eval_item('0, '0, '0));
    dir.push_back(eval_item('1, '1, '1));
    dir.push_back(eval_item(CW'(ONE / 2), CW'(ONE / 2), CW'(ONE / 2)));
    dir.push_back(eval_item(CW'(ONE - 1), '0, CW'(ONE - 1)));
    dir.push_back(eval_item({8'hff, 16'h0001}, {8'h00, 16'hffff}, {8'h80, 16'h8000}));
    dir.push_back(eval_item(24'haaaaaa, 24'h555555, 24'hf0f0f0));
    for (int i = 0; i < 16; i++) dir.push_back(load_item(8'(i), 8'(i)));
    dir.push_back(load_item(8'hff, 8'hff));

    // Integer lattice points give zero noise.
    s = eval_item({8'd7, 16'd0}, {8'd200, 16'd0}, {8'd255, 16'd0});
    s.known = 1'b1;
    s.want = '0;
    dir.push_back(s);

    foreach (dir[i]) send(dir[i]);
    start <= 1'b0;

    // Pause until drained.
    while (noise_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 53 : (ph == 2) ? 0 : 34;
      repeat (192) begin
        if ($urandom_range(9) < 2) begin
          send(load_item(8'($urandom), 8'($urandom)));
        end else begin
          case ($urandom_range(3))
            0: s = eval_item(CW'($urandom), CW'($urandom), CW'($urandom));
            1: s = eval_item({8'($urandom), 16'($urandom_range(1))},
                             {8'($urandom), 16'hffff - 16'($urandom_range(1))},
                             CW'($urandom));
            2: s = eval_item({8'hff, 16'($urandom)}, {8'h00, 16'($urandom)},
                             {8'hff, 16'($urandom)});
            default: s = eval_item(CW'($urandom), {8'($urandom), 16'h8000},
                                   {8'($urandom), 16'h0000});
          endcase
          send(s);
        end
        n++;
      end
    end
    start <= 1'b0;

    while (noise_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
